/* hw/rtl/tlu_pkg.sv */
package tlu_pkg;

  localparam int DATA_W        = 32;
  localparam int ROW_W         = 6;
  localparam int STAT_W        = 2;
  localparam int MAX_ROWS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIV,
    ST_PIVW,
    ST_FWD,
    ST_FWDW,
    ST_FDIV,
    ST_FDIVW,
    ST_BRD,
    ST_BRDW,
    ST_BMACW,
    ST_BDIVW,
    ST_BOUT
  } tlu_state_e;

  // flags returned by the multiply-subtract unit
  typedef struct packed {
    logic done;
    logic sat;
  } tlu_mac_st_t;

  // flags returned by the divider
  typedef struct packed {
    logic done;
    logic sat;
    logic zero;
  } tlu_div_st_t;

endpackage

/* hw/rtl/tridiagonal_lu_solver.sv */
// Thomas-algorithm tridiagonal solver, signed fixed point with FRAC_BITS
// fraction bits. Send rows 0..n-1 as requests; the row flagged last_row_i
// (or row MAX_ROWS-1) starts back substitution, which returns x[n-1] down to
// x[0], last_result_o marking x[0]. A row costs its acceptance, two
// passes through the multiply-subtract unit and, but for the last row, one
// divide, with Q16.16 operands by default; each solution entry costs one
// pass through the same unit and one divide, Q16.16 by default, in the same
// serial divider, plus any output stall. The input stalls for all of that.
// Any zero pivot marks every result of the run singular; otherwise any
// saturation marks status 2 (in back substitution, only on that entry).
module tridiagonal_lu_solver import tlu_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] diag_coef_i,
  input  logic signed [DATA_W-1:0] upper_coef_i,
  input  logic signed [DATA_W-1:0] lower_coef_i,
  input  logic signed [DATA_W-1:0] rhs_value_i,
  input  logic                     last_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ROW_W-1:0]         row_index_o,
  output logic signed [DATA_W-1:0] solution_value_o,
  output logic [STAT_W-1:0]        status_o,
  output logic                     last_result_o
);

  localparam int IDXW = $clog2(MAX_ROWS);

  tlu_state_e state_q, state_d;

  // latched request
  logic signed [DATA_W-1:0] diag_q, upper_q, lower_q, rhs_q;
  logic                     last_q;

  // run state
  logic signed [DATA_W-1:0] prev_ratio_q, prev_upper_q, prev_fwd_q;
  logic [IDXW-1:0]          row_cnt_q;
  logic                     sing_q, sat_seen_q, fsat_q;
  logic signed [DATA_W-1:0] piv_q;

  // back substitution
  logic [IDXW-1:0]          bi_q;
  logic signed [DATA_W-1:0] xnext_q, x_q;
  logic                     esat_q;

  // row stores
  logic signed [DATA_W-1:0] piv_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] up_mem  [MAX_ROWS];
  logic signed [DATA_W-1:0] fwd_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] piv_rd_q, up_rd_q, fwd_rd_q;
  logic                     mem_we;

  // output register
  logic                     out_valid_q;
  logic [ROW_W-1:0]         row_q;
  logic signed [DATA_W-1:0] sol_q;
  logic [STAT_W-1:0]        stat_q;
  logic                     lastres_q;

  // shared units
  logic                     mac_start, div_start;
  logic signed [DATA_W-1:0] mac_a, mac_b, mac_c, mac_res;
  logic signed [DATA_W-1:0] div_num, div_den, div_quo;
  tlu_mac_st_t              mac_st;
  tlu_div_st_t              div_st;

  logic in_acc, out_free, is_last;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = last_q || (row_cnt_q == IDXW'(MAX_ROWS - 1));

  tlu_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .c_i     (mac_c),
    .res_o   (mac_res),
    .st_o    (mac_st)
  );

  tlu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .st_o    (div_st)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    mac_start = 1'b0;
    div_start = 1'b0;
    mac_a     = prev_ratio_q;
    mac_b     = prev_upper_q;
    mac_c     = diag_q;
    div_num   = lower_q;
    div_den   = piv_q;
    mem_we    = 1'b0;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PIV;
      ST_PIV: begin
        mac_start = 1'b1;
        state_d   = ST_PIVW;
      end
      ST_PIVW:  if (mac_st.done) state_d = ST_FWD;
      ST_FWD: begin
        mac_start = 1'b1;
        mac_b     = prev_fwd_q;
        mac_c     = rhs_q;
        state_d   = ST_FWDW;
      end
      ST_FWDW: begin
        if (mac_st.done) begin
          mem_we  = 1'b1;
          state_d = is_last ? ST_BRD : ST_FDIV;
        end
      end
      ST_FDIV: begin
        div_start = 1'b1;
        state_d   = ST_FDIVW;
      end
      ST_FDIVW: if (div_st.done) state_d = ST_IDLE;
      ST_BRD:   state_d = ST_BRDW;
      ST_BRDW: begin
        mac_start = 1'b1;
        mac_a     = up_rd_q;
        mac_b     = xnext_q;
        mac_c     = fwd_rd_q;
        state_d   = ST_BMACW;
      end
      ST_BMACW: begin
        div_num = mac_res;
        div_den = piv_rd_q;
        if (mac_st.done) begin
          div_start = 1'b1;
          state_d   = ST_BDIVW;
        end
      end
      ST_BDIVW: if (div_st.done) state_d = ST_BOUT;
      ST_BOUT: begin
        if (out_free) state_d = (bi_q == '0) ? ST_IDLE : ST_BRD;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ratio_q <= '0;
      prev_upper_q <= '0;
      prev_fwd_q   <= '0;
      row_cnt_q    <= '0;
      sing_q       <= 1'b0;
      sat_seen_q   <= 1'b0;
      fsat_q       <= 1'b0;
      bi_q         <= '0;
      xnext_q      <= '0;
      esat_q       <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: fsat_q <= 1'b0;
        ST_PIVW: begin
          if (mac_st.done) fsat_q <= fsat_q | mac_st.sat;
        end
        ST_FWDW: begin
          if (mac_st.done) begin
            fsat_q <= fsat_q | mac_st.sat;
            if (piv_q == '0) sing_q <= 1'b1;
            if (is_last) begin
              sat_seen_q <= sat_seen_q | fsat_q | mac_st.sat;
              bi_q       <= row_cnt_q;
              xnext_q    <= '0;
            end else begin
              // the unit result is only held in this cycle
              prev_fwd_q <= mac_res;
            end
          end
        end
        ST_FDIVW: begin
          if (div_st.done) begin
            prev_ratio_q <= div_quo;
            prev_upper_q <= upper_q;
            sat_seen_q   <= sat_seen_q | fsat_q | div_st.sat;
            row_cnt_q    <= row_cnt_q + 1'b1;
          end
        end
        ST_BMACW: begin
          if (mac_st.done) esat_q <= mac_st.sat;
        end
        ST_BDIVW: begin
          if (div_st.done) esat_q <= esat_q | div_st.sat;
        end
        ST_BOUT: begin
          if (out_free) begin
            xnext_q <= x_q;
            if (bi_q == '0) begin
              // run finished, back to a clean system
              prev_ratio_q <= '0;
              prev_upper_q <= '0;
              prev_fwd_q   <= '0;
              row_cnt_q    <= '0;
              sing_q       <= 1'b0;
              sat_seen_q   <= 1'b0;
            end else begin
              bi_q <= bi_q - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload holding registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diag_q  <= diag_coef_i;
      upper_q <= upper_coef_i;
      lower_q <= lower_coef_i;
      rhs_q   <= rhs_value_i;
      last_q  <= last_row_i;
    end
    if (state_q == ST_PIVW && mac_st.done) piv_q <= mac_res;
    if (state_q == ST_BDIVW && div_st.done) x_q <= div_quo;
  end

  // row stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      piv_mem[row_cnt_q] <= piv_q;
      up_mem[row_cnt_q]  <= upper_q;
      fwd_mem[row_cnt_q] <= mac_res;
    end
    piv_rd_q <= piv_mem[bi_q];
    up_rd_q  <= up_mem[bi_q];
    fwd_rd_q <= fwd_mem[bi_q];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_BOUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_BOUT && out_free) begin
      row_q     <= ROW_W'(bi_q);
      sol_q     <= x_q;
      lastres_q <= (bi_q == '0);
      if (sing_q)                      stat_q <= STAT_SING;
      else if (esat_q || sat_seen_q)   stat_q <= STAT_SAT;
      else                             stat_q <= STAT_OK;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign row_index_o      = row_q;
  assign solution_value_o = sol_q;
  assign status_o         = stat_q;
  assign last_result_o    = lastres_q;

endmodule

/* hw/rtl/tlu_mac.sv */
// sat(c - sat(round(a*b))), result registered
module tlu_mac import tlu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  input  logic signed [DATA_W-1:0] c_i,
  output logic signed [DATA_W-1:0] res_o,
  output tlu_mac_st_t              st_o
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;

  logic signed [63:0]     prod;
  logic signed [63:0]     sh_q, sh_d;
  logic signed [DATA_W-1:0] c_q;
  logic                   v1_q;
  logic signed [DATA_W-1:0] m;
  logic                   msat;
  logic signed [DATA_W:0] diff;
  logic signed [DATA_W-1:0] res_d;
  logic                   sat_d;
  logic signed [DATA_W-1:0] res_q;
  logic                   sat_q, done_q;

  always_comb begin
    prod = a_i * b_i;
    sh_d = (prod + HALF) >>> FRAC_BITS;
  end

  always_comb begin
    msat = 1'b0;
    if (sh_q > MAXV) begin
      m = 32'sh7FFFFFFF;
      msat = 1'b1;
    end else if (sh_q < MINV) begin
      m = 32'sh80000000;
      msat = 1'b1;
    end else begin
      m = sh_q[DATA_W-1:0];
    end
    diff  = {c_q[DATA_W-1], c_q} - {m[DATA_W-1], m};
    sat_d = msat;
    if (diff[DATA_W] != diff[DATA_W-1]) begin
      sat_d = 1'b1;
      res_d = diff[DATA_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      res_d = diff[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    c_q   <= c_i;
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign res_o   = res_q;
  assign st_o.done = done_q;
  assign st_o.sat  = sat_q;

endmodule

/* hw/rtl/tlu_div.sv */
// (num << FRAC_BITS) / den, truncated, saturated; one quotient bit a cycle
module tlu_div import tlu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] num_i,
  input  logic signed [DATA_W-1:0] den_i,
  output logic signed [DATA_W-1:0] quo_o,
  output tlu_div_st_t              st_o
);

  localparam int NW = DATA_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]     dvd_q, quo_q;
  logic [DATA_W:0]   rem_q;
  logic [DATA_W-1:0] den_q;
  logic              neg_q, busy_q, done_q, sat_q, zero_q;
  logic [CW-1:0]     cnt_q;
  logic signed [DATA_W-1:0] res_q;

  logic signed [DATA_W:0] n33, d33;
  logic [DATA_W-1:0] na, da;
  logic [DATA_W:0]   trial, rem_n;
  logic              qbit;
  logic [NW-1:0]     qfin;
  logic              big, ovf;
  logic signed [DATA_W-1:0] res_d;

  always_comb begin
    n33 = {num_i[DATA_W-1], num_i};
    d33 = {den_i[DATA_W-1], den_i};
    na  = n33[DATA_W] ? DATA_W'(-n33) : n33[DATA_W-1:0];
    da  = d33[DATA_W] ? DATA_W'(-d33) : d33[DATA_W-1:0];
  end

  always_comb begin
    trial = {rem_q[DATA_W-1:0], dvd_q[NW-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_n = qbit ? (trial - {1'b0, den_q}) : trial;
    qfin  = {quo_q[NW-2:0], qbit};
    big   = |qfin[NW-1:DATA_W];
    if (neg_q) begin
      ovf   = big || (qfin[DATA_W-1] && (|qfin[DATA_W-2:0]));
      res_d = ovf ? 32'sh80000000 : -$signed(qfin[DATA_W-1:0]);
    end else begin
      ovf   = big || qfin[DATA_W-1];
      res_d = ovf ? 32'sh7FFFFFFF : $signed(qfin[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(NW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {na, {FRAC_BITS{1'b0}}};
      den_q  <= da;
      neg_q  <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      rem_q  <= '0;
      quo_q  <= '0;
      zero_q <= (den_i == '0);
      sat_q  <= 1'b0;
      res_q  <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= qfin;
      if (cnt_q == CW'(1)) begin
        res_q <= res_d;
        sat_q <= ovf;
      end
    end
  end

  assign quo_o     = res_q;
  assign st_o.done = done_q;
  assign st_o.sat  = sat_q;
  assign st_o.zero = zero_q;

endmodule

/* tb/sv/tlu_solution_checker.sv */
module tlu_solution_checker import tlu_pkg::*; #(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [DATA_W-1:0] diag_coef_i,
  input  logic signed [DATA_W-1:0] upper_coef_i,
  input  logic signed [DATA_W-1:0] lower_coef_i,
  input  logic signed [DATA_W-1:0] rhs_value_i,
  input  logic                     last_row_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [ROW_W-1:0]         row_index_i,
  input  logic signed [DATA_W-1:0] solution_value_i,
  input  logic [STAT_W-1:0]        status_i,
  input  logic                     last_result_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       solved_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } solution_t;

  solution_t solution_q[$];

  logic signed [DATA_W-1:0] pivot_mem[MAX_ROWS];
  logic signed [DATA_W-1:0] upper_mem[MAX_ROWS];
  logic signed [DATA_W-1:0] fwd_mem[MAX_ROWS];
  logic signed [DATA_W-1:0] ratio_r, upper_r, fwd_r;
  int  rows_seen;
  bit  singular, any_sat;

  function automatic logic signed [DATA_W-1:0] clamp(longint v, inout bit f);
    if (v > 64'sd2147483647) begin f = 1; return 32'sh7fffffff; end
    if (v < -64'sd2147483648) begin f = 1; return 32'sh80000000; end
    return v[DATA_W-1:0];
  endfunction

  // round to nearest, ties upward; >>> on longint floors
  function automatic logic signed [DATA_W-1:0] qmul(logic signed [DATA_W-1:0] a,
      logic signed [DATA_W-1:0] b, inout bit f);
    longint p;
    p = longint'(a) * longint'(b) + (longint'(1) << (FRAC_BITS - 1));
    return clamp(p >>> FRAC_BITS, f);
  endfunction

  function automatic logic signed [DATA_W-1:0] qsub(logic signed [DATA_W-1:0] a,
      logic signed [DATA_W-1:0] b, inout bit f);
    return clamp(longint'(a) - longint'(b), f);
  endfunction

  function automatic logic signed [DATA_W-1:0] qdiv(logic signed [DATA_W-1:0] n,
      logic signed [DATA_W-1:0] d, inout bit f, inout bit z);
    if (d == 0) begin z = 1; return '0; end
    return clamp((longint'(n) <<< FRAC_BITS) / longint'(d), f);
  endfunction

  task automatic eliminate_row();
    bit fsat, zero, last;
    int idx, n, i;
    logic signed [DATA_W-1:0] piv, fwd, x, num, xnext, prd;
    solution_t s;
    solution_t run[$];
    fsat = 0; zero = 0; xnext = '0;
    idx  = rows_seen;
    last = last_row_i || (idx >= MAX_ROWS - 1);
    // products first, so each flag update is seen by the next call
    prd  = qmul(ratio_r, upper_r, fsat);
    piv  = qsub(diag_coef_i, prd, fsat);
    prd  = qmul(ratio_r, fwd_r, fsat);
    fwd  = qsub(rhs_value_i, prd, fsat);
    pivot_mem[idx] = piv;
    upper_mem[idx] = upper_coef_i;
    fwd_mem[idx]   = fwd;
    if (!last) begin
      ratio_r = qdiv(lower_coef_i, piv, fsat, zero);
      upper_r = upper_coef_i;
      fwd_r   = fwd;
      if (zero) singular = 1;
      if (fsat) any_sat = 1;
      rows_seen = idx + 1;
      return;
    end
    if (fsat) any_sat = 1;
    n = idx + 1;
    // back substitution, highest index first
    for (i = n - 1; i >= 0; i--) begin
      bit esat, ezero;
      esat = 0; ezero = 0;
      num = fwd_mem[i];
      if (i != n - 1) begin
        prd = qmul(upper_mem[i], xnext, esat);
        num = qsub(num, prd, esat);
      end
      x = qdiv(num, pivot_mem[i], esat, ezero);
      if (ezero) singular = 1;
      xnext    = x;
      s.row    = i[ROW_W-1:0];
      s.value  = x;
      s.last   = (i == 0);
      s.status = (esat || any_sat) ? STAT_SAT : STAT_OK;
      run.push_back(s);
    end
    foreach (run[k]) begin
      if (singular) run[k].status = STAT_SING;
      solution_q.push_back(run[k]);
    end
    ratio_r = '0; upper_r = '0; fwd_r = '0;
    rows_seen = 0; singular = 0; any_sat = 0;
    solved_o++;
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch %0s: got %0d expected %0d at %0t", field, got, want, $time);
    errors_o++;
  endtask

  initial begin
    errors_o = 0; solved_o = 0;
    ratio_r = '0; upper_r = '0; fwd_r = '0;
    rows_seen = 0; singular = 0; any_sat = 0;
  end

  assign pending_o = solution_q.size();

  always @(posedge clk_i) begin
    solution_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) eliminate_row();
      if (out_valid_i && !out_stall_i) begin
        if (solution_q.size() == 0) begin
          report("unexpected result, row", row_index_i, -1);
        end else begin
          w = solution_q.pop_front();
          if (row_index_i !== w.row) report("row_index", row_index_i, w.row);
          if (solution_value_i !== w.value)
            report("solution_value", solution_value_i, w.value);
          if (status_i !== w.status) report("status", status_i, w.status);
          if (last_result_i !== w.last) report("last_result", last_result_i, w.last);
        end
      end
    end
  end

endmodule

/* tb/sv/tb_tridiagonal_lu_solver.sv */
module tb_tridiagonal_lu_solver;
  import tlu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT     = 1500000; // cycles before the run is abandoned
  localparam int LONG_HOLD = 3000;    // receiver hold-off, well past a full row
  localparam int ONE       = 1 << FRAC_BITS_DEF;

  logic                     clk_i = 0;
  logic                     rst_ni = 0;
  logic                     in_valid_i = 0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] diag_coef_i = '0;
  logic signed [DATA_W-1:0] upper_coef_i = '0;
  logic signed [DATA_W-1:0] lower_coef_i = '0;
  logic signed [DATA_W-1:0] rhs_value_i = '0;
  logic                     last_row_i = 0;
  logic                     out_valid_o;
  logic                     out_stall_i = 0;
  logic [ROW_W-1:0]         row_index_o;
  logic signed [DATA_W-1:0] solution_value_o;
  logic [STAT_W-1:0]        status_o;
  logic                     last_result_o;

  int errors, pending, solved;
  int tx_pct = 0, rx_pct = 0;   // idle percentages for sender and receiver
  int requests = 0;
  bit hold_req = 0;

  tridiagonal_lu_solver dut (.*);

  tlu_solution_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .diag_coef_i, .upper_coef_i, .lower_coef_i, .rhs_value_i, .last_row_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .row_index_i(row_index_o), .solution_value_i(solution_value_o),
    .status_i(status_o), .last_result_i(last_result_o),
    .errors_o(errors), .pending_o(pending), .solved_o(solved)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off once requested so the
  // solver backs up and stalls its own input
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0; hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  // one request; idle gaps go before valid is raised
  task automatic send_row(logic signed [DATA_W-1:0] d, u, l, r, logic last);
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    diag_coef_i  <= d;
    upper_coef_i <= u;
    lower_coef_i <= l;
    rhs_value_i  <= r;
    last_row_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests++;
  endtask

  // mostly modest values so runs stay unsaturated; now and then full range
  function automatic logic signed [DATA_W-1:0] rnd_coef();
    if ($urandom_range(7) == 0) return $urandom;
    return $signed($urandom_range(16 * ONE)) - 8 * ONE;
  endfunction

  // diagonally heavy, occasionally zero or full range
  function automatic logic signed [DATA_W-1:0] rnd_diag();
    int m;
    if ($urandom_range(39) == 0) return '0;
    if ($urandom_range(9) == 0) return $urandom;
    m = $urandom_range(16 * ONE, 4 * ONE);
    return $urandom_range(1) ? -m : m;
  endfunction

  task automatic send_system(int rows);
    for (int i = 0; i < rows; i++)
      send_row(rnd_diag(), rnd_coef(), rnd_coef(), rnd_coef(), i == rows - 1);
  endtask

  task automatic random_phase(int budget);
    int target, n;
    target = requests + budget;
    while (requests < target) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
      send_system(n);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 1x1, a plain 3x3, a zero pivot, saturation, field extremes
    send_row(2 * ONE, 0, 0, 3 * ONE, 1'b1);
    send_row(4 * ONE, ONE, ONE, ONE, 1'b0);
    send_row(4 * ONE, -ONE, 2 * ONE, -5 * ONE, 1'b0);
    send_row(4 * ONE, 0, 0, 7 * ONE, 1'b1);
    send_row(0, ONE, ONE, ONE, 1'b0);
    send_row(2 * ONE, 0, 0, ONE, 1'b1);
    send_row(1, 0, 0, 32'sh7fffffff, 1'b1);
    send_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0);
    send_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1);
    send_row(32'shffffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh00000001, 1'b0);
    send_row(ONE, 0, 0, 32'sh80000000, 1'b1);
    send_row(32'sh80000000, 0, 0, 32'sh80000000, 1'b1);
    in_valid_i <= 1'b0;
    wait (pending == 0);

    tx_pct = 21; rx_pct = 61;
    random_phase(28);

    tx_pct = 61; rx_pct = 21;
    hold_req = 1;
    random_phase(28);

    tx_pct = 0; rx_pct = 0;
    // a full-size system with no last flag: the final slot closes it
    send_system(0);
    for (int i = 0; i < MAX_ROWS_DEF; i++)
      send_row(rnd_diag(), rnd_coef(), rnd_coef(), rnd_coef(), 1'b0);
    random_phase(28);

    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk_i);

    $display("%0d rows in %0d systems, sizes 1 to %0d, zero pivots and saturation",
             requests, solved, MAX_ROWS_DEF);
    $display("sender and receiver stalls varied, one long receiver hold-off");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
